// ===== rtl/jt2sj_pkg.sv =====
`default_nettype none

package jt2sj_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // register indexes
   localparam logic CSR_SOURCE_ENCODING = 1'b0;
   localparam logic CSR_FULL_WIDTH_KANA = 1'b1;

   // source encodings, any other code behaves as shift-jis
   localparam logic [1:0] ENC_EUC_JP = 2'd0;
   localparam logic [1:0] ENC_ISO_2022_JP = 2'd1;

   localparam logic [7:0] BYTE_END      = 8'd0;
   localparam logic [7:0] BYTE_FF       = 8'd12;
   localparam logic [7:0] BYTE_CR       = 8'd13;
   localparam logic [7:0] BYTE_ESC      = 8'd27;
   localparam logic [7:0] BYTE_DOLLAR   = 8'd36;
   localparam logic [7:0] BYTE_LPAREN   = 8'd40;
   localparam logic [7:0] BYTE_K        = 8'd75;
   localparam logic [7:0] BYTE_SS2      = 8'd142;
   localparam logic [7:0] MARK_NIGORI   = 8'd222;
   localparam logic [7:0] MARK_MARU     = 8'd223;
   localparam logic [7:0] HANKATA_FIRST = 8'd161;
   localparam logic [7:0] HANKATA_LAST  = 8'd223;
   localparam logic [7:0] SEVEN_BIT     = 8'h7F;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEAD    = 3'd1,
      PH_SS2     = 3'd2,
      PH_KWAIT   = 3'd3,
      PH_KSS2    = 3'd4,
      PH_ESC     = 3'd5,
      PH_ESCSKIP = 3'd6,
      PH_KSJ     = 3'd7
   } phase_type;

   // one group of output bytes caused by one input transaction
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   localparam logic [15:0] KANA_WIDE [0:62] = '{
      16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h8392, 16'h8340, 16'h8342,
      16'h8344, 16'h8346, 16'h8348, 16'h8383, 16'h8385, 16'h8387, 16'h8362, 16'h815B,
      16'h8341, 16'h8343, 16'h8345, 16'h8347, 16'h8349, 16'h834A, 16'h834C, 16'h834E,
      16'h8350, 16'h8352, 16'h8354, 16'h8356, 16'h8358, 16'h835A, 16'h835C, 16'h835E,
      16'h8360, 16'h8363, 16'h8365, 16'h8367, 16'h8369, 16'h836A, 16'h836B, 16'h836C,
      16'h836D, 16'h836E, 16'h8371, 16'h8374, 16'h8377, 16'h837A, 16'h837D, 16'h837E,
      16'h8380, 16'h8381, 16'h8382, 16'h8384, 16'h8386, 16'h8388, 16'h8389, 16'h838A,
      16'h838B, 16'h838C, 16'h838D, 16'h838F, 16'h8393, 16'h814A, 16'h814B
   };

endpackage

`default_nettype wire

// ===== rtl/jt2sj_front.sv =====
`default_nettype none

module jt2sj_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [7:0]                in_byte,
   input  wire logic [1:0]                source_encoding,
   input  wire logic                      full_width_kana,
   output jt2sj_pkg::entry_type           push_entry,
   output logic                           push
);

   typedef struct packed {
      jt2sj_pkg::phase_type ph;
      logic                 emit;
   } idle_res_type;

   typedef struct packed {
      jt2sj_pkg::phase_type ph;
      logic                 emit_one;
      logic                 emit_two;
   } ss2_res_type;

   function automatic logic is_hankata(input logic [7:0] b);
      return b >= jt2sj_pkg::HANKATA_FIRST && b <= jt2sj_pkg::HANKATA_LAST;
   endfunction

   function automatic logic can_nigori(input logic [7:0] k);
      return (k >= 8'd182 && k <= 8'd196) || (k >= 8'd202 && k <= 8'd206) || k == 8'd179;
   endfunction

   function automatic logic can_maru(input logic [7:0] k);
      return k >= 8'd202 && k <= 8'd206;
   endfunction

   function automatic logic mark_merges(input logic [7:0] k, input logic [7:0] m);
      return (m == jt2sj_pkg::MARK_NIGORI && can_nigori(k)) ||
             (m == jt2sj_pkg::MARK_MARU && can_maru(k));
   endfunction

   function automatic logic [15:0] kana_pair(input logic [7:0] k, input logic [7:0] m);
      logic [5:0]  idx;
      logic [15:0] w;
      logic [7:0]  one;
      logic [7:0]  two;
      idx = is_hankata(k) ? 6'(k - jt2sj_pkg::HANKATA_FIRST) : 6'd0;
      w   = jt2sj_pkg::KANA_WIDE[idx];
      one = w[15:8];
      two = w[7:0];
      if (m == jt2sj_pkg::MARK_NIGORI && can_nigori(k)) begin
         if ((two >= 8'd74 && two <= 8'd103) || (two >= 8'd110 && two <= 8'd122)) begin
            two = two + 8'd1;
         end else if (one == 8'd131 && two == 8'd69) begin
            two = 8'd148;
         end
      end else if (m == jt2sj_pkg::MARK_MARU && can_maru(k) &&
                   two >= 8'd110 && two <= 8'd122) begin
         two = two + 8'd2;
      end
      return {one, two};
   endfunction

   function automatic logic [15:0] jis_pair(input logic [7:0] p1, input logic [7:0] p2);
      logic [7:0] row;
      logic [7:0] col;
      logic [8:0] half;
      logic [7:0] one;
      logic [7:0] two;
      row  = (p1 < 8'd95) ? 8'd112 : 8'd176;
      col  = p1[0] ? ((p2 > 8'd95) ? 8'd32 : 8'd31) : 8'd126;
      half = ({1'b0, p1} + 9'd1) >> 1;
      one  = half[7:0] + row;
      two  = p2 + col;
      return {one, two};
   endfunction

   function automatic idle_res_type from_idle(input logic [7:0] b, input logic [1:0] enc,
                                              input logic fwk, input logic dbs);
      idle_res_type r;
      r.ph   = jt2sj_pkg::PH_IDLE;
      r.emit = 1'b0;
      if (enc == jt2sj_pkg::ENC_EUC_JP) begin
         priority if (b == jt2sj_pkg::BYTE_FF) r.emit = 1'b0;
         else if (b > 8'd160) r.ph = jt2sj_pkg::PH_LEAD;
         else if (b == jt2sj_pkg::BYTE_SS2) r.ph = jt2sj_pkg::PH_SS2;
         else r.emit = 1'b1;
      end else if (enc == jt2sj_pkg::ENC_ISO_2022_JP) begin
         priority if (b == jt2sj_pkg::BYTE_ESC) r.ph = jt2sj_pkg::PH_ESC;
         else if (b == jt2sj_pkg::BYTE_FF) r.emit = 1'b0;
         else if (dbs) r.ph = jt2sj_pkg::PH_LEAD;
         else r.emit = 1'b1;
      end else begin
         priority if (b == jt2sj_pkg::BYTE_FF || b == jt2sj_pkg::BYTE_CR) r.emit = 1'b0;
         else if ((b >= 8'd129 && b <= 8'd159) || (b >= 8'd224 && b <= 8'd239))
            r.ph = jt2sj_pkg::PH_LEAD;
         else if (is_hankata(b) && fwk) r.ph = jt2sj_pkg::PH_KSJ;
         else r.emit = 1'b1;
      end
      return r;
   endfunction

   // emit_two means ss2 then the byte, emit_one means the byte alone
   function automatic ss2_res_type after_ss2(input logic [7:0] b, input logic fwk);
      ss2_res_type r;
      r.ph       = jt2sj_pkg::PH_IDLE;
      r.emit_one = 1'b0;
      r.emit_two = 1'b0;
      if (is_hankata(b)) begin
         if (fwk) r.ph = jt2sj_pkg::PH_KWAIT;
         else r.emit_one = 1'b1;
      end else begin
         r.emit_two = 1'b1;
      end
      return r;
   endfunction

   jt2sj_pkg::phase_type phase_ff, phase_in;
   logic [7:0]           lead_ff, lead_in;
   logic [7:0]           kana_ff, kana_in;
   logic                 dbs_ff, dbs_in;

   logic [3:0][7:0] ob;
   logic [2:0]      n;
   logic [15:0]     kana_plain;
   logic [15:0]     kana_marked;
   logic [15:0]     jis;
   logic [7:0]      lead_src;
   logic [7:0]      trail_src;
   idle_res_type    idle_r;
   ss2_res_type     ss2_r;

   always_comb begin
      kana_plain  = kana_pair(kana_ff, 8'd0);
      kana_marked = kana_pair(kana_ff, in_byte);
      idle_r      = from_idle(in_byte, source_encoding, full_width_kana, dbs_ff);
      ss2_r       = after_ss2(in_byte, full_width_kana);
      if (source_encoding == jt2sj_pkg::ENC_EUC_JP) begin
         lead_src  = lead_ff & jt2sj_pkg::SEVEN_BIT;
         trail_src = in_byte & jt2sj_pkg::SEVEN_BIT;
      end else begin
         lead_src  = lead_ff;
         trail_src = in_byte;
      end
      jis = jis_pair(lead_src, trail_src);
   end

   always_comb begin
      ob       = '0;
      n        = 3'd0;
      phase_in = phase_ff;
      lead_in  = lead_ff;
      kana_in  = kana_ff;
      dbs_in   = dbs_ff;
      if (in_byte == jt2sj_pkg::BYTE_END) begin
         if (phase_ff == jt2sj_pkg::PH_KWAIT || phase_ff == jt2sj_pkg::PH_KSS2 ||
             phase_ff == jt2sj_pkg::PH_KSJ) begin
            ob[0] = kana_plain[15:8];
            ob[1] = kana_plain[7:0];
            n     = 3'd2;
         end
         phase_in = jt2sj_pkg::PH_IDLE;
         lead_in  = 8'd0;
         kana_in  = 8'd0;
         dbs_in   = 1'b0;
      end else begin
         unique case (phase_ff)
            jt2sj_pkg::PH_IDLE: begin
               phase_in = idle_r.ph;
               if (idle_r.emit) begin
                  ob[0] = in_byte;
                  n     = 3'd1;
               end
            end
            jt2sj_pkg::PH_LEAD: begin
               phase_in = jt2sj_pkg::PH_IDLE;
               lead_in  = 8'd0;
               if (source_encoding == jt2sj_pkg::ENC_EUC_JP) begin
                  if (in_byte > 8'd160) begin
                     ob[0] = jis[15:8];
                     ob[1] = jis[7:0];
                  end else begin
                     ob[0] = lead_ff;
                     ob[1] = in_byte;
                  end
                  n = 3'd2;
               end else if (source_encoding == jt2sj_pkg::ENC_ISO_2022_JP) begin
                  ob[0] = jis[15:8];
                  ob[1] = jis[7:0];
                  n     = 3'd2;
               end else if (in_byte >= 8'd64 && in_byte <= 8'd252) begin
                  ob[0] = lead_ff;
                  ob[1] = in_byte;
                  n     = 3'd2;
               end
            end
            jt2sj_pkg::PH_SS2: begin
               phase_in = ss2_r.ph;
               if (ss2_r.emit_one) begin
                  ob[0] = in_byte;
                  n     = 3'd1;
               end else if (ss2_r.emit_two) begin
                  ob[0] = jt2sj_pkg::BYTE_SS2;
                  ob[1] = in_byte;
                  n     = 3'd2;
               end
            end
            jt2sj_pkg::PH_KWAIT: begin
               if (in_byte == jt2sj_pkg::BYTE_SS2) begin
                  phase_in = jt2sj_pkg::PH_KSS2;
               end else begin
                  ob[0]    = kana_plain[15:8];
                  ob[1]    = kana_plain[7:0];
                  n        = 3'd2;
                  phase_in = idle_r.ph;
                  if (idle_r.emit) begin
                     ob[2] = in_byte;
                     n     = 3'd3;
                  end
               end
            end
            jt2sj_pkg::PH_KSS2, jt2sj_pkg::PH_KSJ: begin
               phase_in = jt2sj_pkg::PH_IDLE;
               if (mark_merges(kana_ff, in_byte)) begin
                  ob[0] = kana_marked[15:8];
                  ob[1] = kana_marked[7:0];
                  n     = 3'd2;
               end else begin
                  ob[0] = kana_plain[15:8];
                  ob[1] = kana_plain[7:0];
                  n     = 3'd2;
                  if (phase_ff == jt2sj_pkg::PH_KSS2) begin
                     phase_in = ss2_r.ph;
                     if (ss2_r.emit_one) begin
                        ob[2] = in_byte;
                        n     = 3'd3;
                     end else if (ss2_r.emit_two) begin
                        ob[2] = jt2sj_pkg::BYTE_SS2;
                        ob[3] = in_byte;
                        n     = 3'd4;
                     end
                  end else begin
                     phase_in = idle_r.ph;
                     if (idle_r.emit) begin
                        ob[2] = in_byte;
                        n     = 3'd3;
                     end
                  end
               end
            end
            jt2sj_pkg::PH_ESC: begin
               dbs_in = (in_byte == jt2sj_pkg::BYTE_DOLLAR || in_byte == jt2sj_pkg::BYTE_K);
               phase_in = (in_byte == jt2sj_pkg::BYTE_DOLLAR ||
                           in_byte == jt2sj_pkg::BYTE_LPAREN) ?
                          jt2sj_pkg::PH_ESCSKIP : jt2sj_pkg::PH_IDLE;
            end
            jt2sj_pkg::PH_ESCSKIP: begin
               phase_in = jt2sj_pkg::PH_IDLE;
            end
            default: begin
               phase_in = jt2sj_pkg::PH_IDLE;
            end
         endcase
         // entering the lead, kana-wait or shift-jis kana phase captures the current byte
         if (phase_in == jt2sj_pkg::PH_LEAD) lead_in = in_byte;
         if (phase_in == jt2sj_pkg::PH_KWAIT || phase_in == jt2sj_pkg::PH_KSJ)
            kana_in = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jt2sj_pkg::PH_IDLE;
         lead_ff  <= 8'd0;
         kana_ff  <= 8'd0;
         dbs_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         lead_ff  <= lead_in;
         kana_ff  <= kana_in;
         dbs_ff   <= dbs_in;
      end
   end

   assign push                = accept && (n != 3'd0);
   assign push_entry.bytes    = ob;
   assign push_entry.last_idx = 2'(n - 3'd1);

endmodule

`default_nettype wire

// ===== rtl/jt2sj_queue.sv =====
`default_nettype none

module jt2sj_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  jt2sj_pkg::entry_type             push_entry,
   input  wire logic                        pop,
   output jt2sj_pkg::entry_type             head_entry,
   output jt2sj_pkg::queue_status_type      status
);

   jt2sj_pkg::entry_type slots_ff [jt2sj_pkg::QUEUE_DEPTH];

   // one extra pointer bit tells full from empty
   logic [jt2sj_pkg::QUEUE_AW:0] wr_ptr_ff, wr_ptr_in;
   logic [jt2sj_pkg::QUEUE_AW:0] rd_ptr_ff, rd_ptr_in;
   logic [jt2sj_pkg::QUEUE_AW:0] ptr_one;

   assign ptr_one = {{jt2sj_pkg::QUEUE_AW{1'b0}}, 1'b1};

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + ptr_one : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + ptr_one : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff[jt2sj_pkg::QUEUE_AW-1:0]] <= push_entry;
   end

   assign head_entry   = slots_ff[rd_ptr_ff[jt2sj_pkg::QUEUE_AW-1:0]];
   assign status.empty = (wr_ptr_ff == rd_ptr_ff);
   assign status.full  = (wr_ptr_ff[jt2sj_pkg::QUEUE_AW] != rd_ptr_ff[jt2sj_pkg::QUEUE_AW]) &&
                         (wr_ptr_ff[jt2sj_pkg::QUEUE_AW-1:0] ==
                          rd_ptr_ff[jt2sj_pkg::QUEUE_AW-1:0]);

endmodule

`default_nettype wire

// ===== rtl/jt2sj_back.sv =====
`default_nettype none

module jt2sj_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  jt2sj_pkg::entry_type             head_entry,
   input  jt2sj_pkg::queue_status_type      status,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last_of_run
);

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign rsp_valid       = !status.empty;
   assign rsp_out_byte    = head_entry.bytes[idx_ff];
   assign rsp_last_of_run = (idx_ff == head_entry.last_idx);
   assign take            = rsp_valid && rsp_ready;
   assign pop             = take && rsp_last_of_run;

   // walk through the bytes of the head group, release it after its last byte
   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = rsp_last_of_run ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/japanese_text_to_shift_jis.sv =====
`default_nettype none

// Converts an EUC-JP, 7-bit ISO-2022-JP or Shift-JIS byte stream to Shift-JIS, with
// optional widening of half-width katakana (merging a following voiced or semi-voiced
// mark). Each input transaction yields zero to four output bytes; rsp_last_of_run marks
// the final byte of each group. A byte of 0 ends the text, flushes a waiting kana and
// clears the decoder state. The front end takes one input byte per cycle while its
// four-group queue has room; the back end sends one output byte per cycle while
// rsp_ready is high, so once output bytes outnumber input bytes the output side sets
// the pace. Registers (source_encoding at index 0, full_width_kana at index 1) are
// written through csr_we; the user must do so only while no transaction is in flight,
// which the block does not enforce. Reset is synchronous and active high.
module japanese_text_to_shift_jis (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [1:0]  csr_wdata
);

   logic [1:0] source_encoding_ff;
   logic       full_width_kana_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_encoding_ff <= 2'd0;
         full_width_kana_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            jt2sj_pkg::CSR_SOURCE_ENCODING: source_encoding_ff <= csr_wdata;
            jt2sj_pkg::CSR_FULL_WIDTH_KANA: full_width_kana_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   jt2sj_pkg::entry_type        push_entry;
   jt2sj_pkg::entry_type        head_entry;
   jt2sj_pkg::queue_status_type status;
   logic                        push;
   logic                        pop;
   logic                        accept;

   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   jt2sj_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .source_encoding (source_encoding_ff),
      .full_width_kana (full_width_kana_ff),
      .push_entry      (push_entry),
      .push            (push)
   );

   jt2sj_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   jt2sj_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .status          (status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] ENC_SHIFT_JIS = 2'd2;
   localparam logic [1:0] ENC_SPARE     = 2'd3;
   localparam logic [1:0] KANA_HALF     = 2'd0;
   localparam logic [1:0] KANA_FULL     = 2'd1;
   localparam logic [7:0] NO_MARK       = 8'd0;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_PER_SETTING = 15;

   localparam logic [15:0] WIDE_KANA [63] = '{
      16'h8142, 16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h8392, 16'h8340, 16'h8342,
      16'h8344, 16'h8346, 16'h8348, 16'h8383, 16'h8385, 16'h8387, 16'h8362, 16'h815B,
      16'h8341, 16'h8343, 16'h8345, 16'h8347, 16'h8349, 16'h834A, 16'h834C, 16'h834E,
      16'h8350, 16'h8352, 16'h8354, 16'h8356, 16'h8358, 16'h835A, 16'h835C, 16'h835E,
      16'h8360, 16'h8363, 16'h8365, 16'h8367, 16'h8369, 16'h836A, 16'h836B, 16'h836C,
      16'h836D, 16'h836E, 16'h8371, 16'h8374, 16'h8377, 16'h837A, 16'h837D, 16'h837E,
      16'h8380, 16'h8381, 16'h8382, 16'h8384, 16'h8386, 16'h8388, 16'h8389, 16'h838A,
      16'h838B, 16'h838C, 16'h838D, 16'h838F, 16'h8393, 16'h814A, 16'h814B
   };

   typedef struct {
      logic [7:0] out_byte;
      logic       last_of_run;
   } sjis_out_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_we;
   logic       csr_index;
   logic [1:0] csr_wdata;

   // converter state as the predictor sees it
   logic [1:0]           enc_cfg;
   logic                 kana_cfg;
   jt2sj_pkg::phase_type dec_phase;
   logic [7:0]           lead_byte;
   logic [7:0]           kana_byte;
   logic                 dbl_shift;

   logic [7:0]   run_bytes[$];
   sjis_out_type sjis_expected[$];

   int  mismatches;
   int  quiet_cycles;
   int  bytes_in;
   int  bytes_out;
   int  settings_run;
   bit  no_idle;

   japanese_text_to_shift_jis dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit hankata(input logic [7:0] b);
      return b >= jt2sj_pkg::HANKATA_FIRST && b <= jt2sj_pkg::HANKATA_LAST;
   endfunction

   function automatic bit sjis_lead(input logic [7:0] b);
      return (b >= 129 && b <= 159) || (b >= 224 && b <= 239);
   endfunction

   function automatic bit nigori_ok(input logic [7:0] k);
      return (k >= 182 && k <= 196) || (k >= 202 && k <= 206) || k == 179;
   endfunction

   function automatic bit maru_ok(input logic [7:0] k);
      return k >= 202 && k <= 206;
   endfunction

   function automatic bit mark_joins(input logic [7:0] k, input logic [7:0] m);
      return (m == jt2sj_pkg::MARK_NIGORI && nigori_ok(k)) ||
             (m == jt2sj_pkg::MARK_MARU && maru_ok(k));
   endfunction

   function automatic void put_wide_kana(input logic [7:0] k, input logic [7:0] m);
      logic [15:0] code;
      int hi;
      int lo;
      code = hankata(k) ? WIDE_KANA[6'(k - jt2sj_pkg::HANKATA_FIRST)] : WIDE_KANA[0];
      hi = code[15:8];
      lo = code[7:0];
      if (m == jt2sj_pkg::MARK_NIGORI && nigori_ok(k)) begin
         if ((lo >= 74 && lo <= 103) || (lo >= 110 && lo <= 122)) lo++;
         // u with a voiced mark becomes vu
         else if (hi == 131 && lo == 69) lo = 148;
      end else if (m == jt2sj_pkg::MARK_MARU && maru_ok(k) && lo >= 110 && lo <= 122) begin
         lo += 2;
      end
      run_bytes.push_back(hi[7:0]);
      run_bytes.push_back(lo[7:0]);
   endfunction

   // jis row/cell pair to shift-jis, wraps above 255
   function automatic void put_jis(input int p1, input int p2);
      int row;
      int col;
      int first;
      int second;
      row = (p1 < 95) ? 112 : 176;
      col = p1[0] ? 31 + ((p2 > 95) ? 1 : 0) : 126;
      first = ((p1 + 1) >> 1) + row;
      second = p2 + col;
      run_bytes.push_back(first[7:0]);
      run_bytes.push_back(second[7:0]);
   endfunction

   function automatic void decode_idle(input logic [7:0] b);
      dec_phase = jt2sj_pkg::PH_IDLE;
      if (enc_cfg == jt2sj_pkg::ENC_EUC_JP) begin
         if (b == jt2sj_pkg::BYTE_FF) return;
         if (b >= jt2sj_pkg::HANKATA_FIRST) begin
            lead_byte = b;
            dec_phase = jt2sj_pkg::PH_LEAD;
         end else if (b == jt2sj_pkg::BYTE_SS2) begin
            dec_phase = jt2sj_pkg::PH_SS2;
         end else begin
            run_bytes.push_back(b);
         end
      end else if (enc_cfg == jt2sj_pkg::ENC_ISO_2022_JP) begin
         if (b == jt2sj_pkg::BYTE_ESC) begin
            dec_phase = jt2sj_pkg::PH_ESC;
         end else if (b != jt2sj_pkg::BYTE_FF) begin
            if (dbl_shift) begin
               lead_byte = b;
               dec_phase = jt2sj_pkg::PH_LEAD;
            end else begin
               run_bytes.push_back(b);
            end
         end
      end else begin
         if (b == jt2sj_pkg::BYTE_FF || b == jt2sj_pkg::BYTE_CR) return;
         if (sjis_lead(b)) begin
            lead_byte = b;
            dec_phase = jt2sj_pkg::PH_LEAD;
         end else if (hankata(b) && kana_cfg) begin
            kana_byte = b;
            dec_phase = jt2sj_pkg::PH_KSJ;
         end else begin
            run_bytes.push_back(b);
         end
      end
   endfunction

   function automatic void decode_after_ss2(input logic [7:0] b);
      dec_phase = jt2sj_pkg::PH_IDLE;
      if (hankata(b)) begin
         if (kana_cfg) begin
            kana_byte = b;
            dec_phase = jt2sj_pkg::PH_KWAIT;
         end else begin
            run_bytes.push_back(b);
         end
      end else begin
         run_bytes.push_back(jt2sj_pkg::BYTE_SS2);
         run_bytes.push_back(b);
      end
   endfunction

   // predicts the shift-jis bytes caused by one accepted source byte
   function automatic void convert_byte(input logic [7:0] b);
      logic [7:0]           lead;
      logic [7:0]           k;
      jt2sj_pkg::phase_type was;
      sjis_out_type         item;
      lead = lead_byte;
      run_bytes.delete();
      if (b == jt2sj_pkg::BYTE_END) begin
         if (dec_phase == jt2sj_pkg::PH_KWAIT || dec_phase == jt2sj_pkg::PH_KSS2 ||
             dec_phase == jt2sj_pkg::PH_KSJ)
            put_wide_kana(kana_byte, NO_MARK);
         dec_phase = jt2sj_pkg::PH_IDLE;
         lead_byte = 8'd0;
         kana_byte = 8'd0;
         dbl_shift = 1'b0;
      end else begin
         case (dec_phase)
            jt2sj_pkg::PH_IDLE: decode_idle(b);
            jt2sj_pkg::PH_LEAD: begin
               dec_phase = jt2sj_pkg::PH_IDLE;
               lead_byte = 8'd0;
               // trail is read with the encoding in force now
               if (enc_cfg == jt2sj_pkg::ENC_EUC_JP) begin
                  if (b >= jt2sj_pkg::HANKATA_FIRST) begin
                     put_jis(lead & jt2sj_pkg::SEVEN_BIT, b & jt2sj_pkg::SEVEN_BIT);
                  end else begin
                     run_bytes.push_back(lead);
                     run_bytes.push_back(b);
                  end
               end else if (enc_cfg == jt2sj_pkg::ENC_ISO_2022_JP) begin
                  put_jis(lead, b);
               end else if (b >= 64 && b <= 252) begin
                  run_bytes.push_back(lead);
                  run_bytes.push_back(b);
               end
            end
            jt2sj_pkg::PH_SS2: decode_after_ss2(b);
            jt2sj_pkg::PH_KWAIT: begin
               if (b == jt2sj_pkg::BYTE_SS2) begin
                  dec_phase = jt2sj_pkg::PH_KSS2;
               end else begin
                  put_wide_kana(kana_byte, NO_MARK);
                  kana_byte = 8'd0;
                  decode_idle(b);
               end
            end
            jt2sj_pkg::PH_KSS2, jt2sj_pkg::PH_KSJ: begin
               k = kana_byte;
               was = dec_phase;
               kana_byte = 8'd0;
               dec_phase = jt2sj_pkg::PH_IDLE;
               if (mark_joins(k, b)) begin
                  put_wide_kana(k, b);
               end else begin
                  put_wide_kana(k, NO_MARK);
                  if (was == jt2sj_pkg::PH_KSS2) decode_after_ss2(b);
                  else decode_idle(b);
               end
            end
            jt2sj_pkg::PH_ESC: begin
               dbl_shift = (b == jt2sj_pkg::BYTE_DOLLAR || b == jt2sj_pkg::BYTE_K);
               dec_phase = (b == jt2sj_pkg::BYTE_DOLLAR || b == jt2sj_pkg::BYTE_LPAREN) ?
                           jt2sj_pkg::PH_ESCSKIP : jt2sj_pkg::PH_IDLE;
            end
            default: dec_phase = jt2sj_pkg::PH_IDLE;
         endcase
      end
      foreach (run_bytes[i]) begin
         item.out_byte    = run_bytes[i];
         item.last_of_run = (i == run_bytes.size() - 1);
         sjis_expected.push_back(item);
      end
   endfunction

   function automatic logic [7:0] pick_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // prediction and checking, one transaction per side per edge at most
   always @(posedge clock) begin : monitor
      sjis_out_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            convert_byte(req_in_byte);
            bytes_in++;
         end
         if (rsp_valid && rsp_ready) begin
            bytes_out++;
            if (sjis_expected.size() == 0) begin
               $error("out_byte: nothing expected, got %02h (last_of_run %0b)",
                      rsp_out_byte, rsp_last_of_run);
               mismatches++;
            end else begin
               want = sjis_expected.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b",
                         want.last_of_run, rsp_last_of_run);
                  mismatches++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("** japanese_text_to_shift_jis: FAILED **");
            $finish;
         end
      end
   end

   // output side back-pressure
   initial begin : sink
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] text[]);
      foreach (text[i]) send_byte(text[i]);
   endtask

   task automatic write_reg(input logic index, input logic [1:0] value);
      req_valid <= 1'b0;
      while (sjis_expected.size() != 0) @(negedge clock);
      // a held byte may still be in flight with nothing expected
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == jt2sj_pkg::CSR_SOURCE_ENCODING) enc_cfg = value;
      else kana_cfg = value[0];
   endtask

   task automatic test_euc_jp();
      logic [7:0] text[] = '{
         jt2sj_pkg::BYTE_FF, 8'hFE, 8'hFE, 8'hB0, 8'h41, jt2sj_pkg::BYTE_SS2, 8'h41,
         jt2sj_pkg::BYTE_SS2, 8'hB6, jt2sj_pkg::BYTE_SS2, jt2sj_pkg::MARK_NIGORI,
         jt2sj_pkg::BYTE_SS2, 8'hB1, jt2sj_pkg::BYTE_SS2, jt2sj_pkg::MARK_MARU,
         jt2sj_pkg::BYTE_END
      };
      write_reg(jt2sj_pkg::CSR_SOURCE_ENCODING, jt2sj_pkg::ENC_EUC_JP);
      write_reg(jt2sj_pkg::CSR_FULL_WIDTH_KANA, KANA_FULL);
      send_text(text);
   endtask

   task automatic test_iso_2022_jp();
      logic [7:0] text[] = '{
         jt2sj_pkg::BYTE_ESC, jt2sj_pkg::BYTE_DOLLAR, 8'h42, 8'hFF, 8'hFF,
         jt2sj_pkg::BYTE_ESC, 8'h41, 8'h80
      };
      write_reg(jt2sj_pkg::CSR_SOURCE_ENCODING, jt2sj_pkg::ENC_ISO_2022_JP);
      send_text(text);
   endtask

   task automatic test_shift_jis();
      logic [7:0] text[] = '{
         jt2sj_pkg::BYTE_CR, 8'h81, 8'h3F, 8'hEF, 8'hFC, 8'hB3, jt2sj_pkg::MARK_NIGORI
      };
      write_reg(jt2sj_pkg::CSR_SOURCE_ENCODING, ENC_SHIFT_JIS);
      send_text(text);
   endtask

   // encoding three, then an encoding switch between lead and trail
   task automatic test_switch_mid_char();
      write_reg(jt2sj_pkg::CSR_SOURCE_ENCODING, ENC_SPARE);
      send_byte(8'h9F);
      write_reg(jt2sj_pkg::CSR_SOURCE_ENCODING, jt2sj_pkg::ENC_EUC_JP);
      send_byte(8'hC1);
   endtask

   task automatic send_random_text(input int count);
      logic [7:0] seq[$];
      int sent;
      int r;
      sent = 0;
      while (sent < count) begin
         seq.delete();
         r = $urandom_range(0, 99);
         if (enc_cfg == jt2sj_pkg::ENC_EUC_JP) begin
            if (r < 25) seq.push_back(pick_byte(1, 127));
            else if (r < 50) begin
               seq.push_back(pick_byte(161, 255));
               seq.push_back(pick_byte(161, 255));
            end else if (r < 62) begin
               seq.push_back(jt2sj_pkg::BYTE_SS2);
               seq.push_back(pick_byte(161, 223));
            end else if (r < 74) begin
               seq.push_back(jt2sj_pkg::BYTE_SS2);
               seq.push_back(pick_byte(176, 210));
               seq.push_back(jt2sj_pkg::BYTE_SS2);
               seq.push_back($urandom_range(0, 1) ? jt2sj_pkg::MARK_NIGORI :
                                                    jt2sj_pkg::MARK_MARU);
            end else if (r < 82) begin
               seq.push_back(pick_byte(161, 255));
               seq.push_back(pick_byte(1, 160));
            end else if (r < 87) begin
               seq.push_back(jt2sj_pkg::BYTE_SS2);
               seq.push_back(pick_byte(1, 255));
            end else if (r < 95) seq.push_back(pick_byte(1, 255));
            else seq.push_back(jt2sj_pkg::BYTE_END);
         end else if (enc_cfg == jt2sj_pkg::ENC_ISO_2022_JP) begin
            if (r < 25) begin
               seq.push_back(jt2sj_pkg::BYTE_ESC);
               case ($urandom_range(0, 3))
                  0: begin
                     seq.push_back(jt2sj_pkg::BYTE_DOLLAR);
                     seq.push_back(pick_byte(1, 255));
                  end
                  1: begin
                     seq.push_back(jt2sj_pkg::BYTE_LPAREN);
                     seq.push_back(pick_byte(1, 255));
                  end
                  2: seq.push_back(jt2sj_pkg::BYTE_K);
                  default: seq.push_back(pick_byte(1, 255));
               endcase
            end else if (r < 55) begin
               seq.push_back(pick_byte(33, 126));
               seq.push_back(pick_byte(33, 126));
            end else if (r < 70) seq.push_back(pick_byte(32, 126));
            else if (r < 75) seq.push_back(jt2sj_pkg::BYTE_FF);
            else if (r < 94) seq.push_back(pick_byte(1, 255));
            else seq.push_back(jt2sj_pkg::BYTE_END);
         end else begin
            if (r < 40) begin
               seq.push_back($urandom_range(0, 1) ? pick_byte(129, 159) : pick_byte(224, 239));
               seq.push_back(r < 30 ? pick_byte(64, 252) : pick_byte(1, 255));
            end else if (r < 62) begin
               seq.push_back(pick_byte(176, 210));
               case ($urandom_range(0, 2))
                  0: seq.push_back(jt2sj_pkg::MARK_NIGORI);
                  1: seq.push_back(jt2sj_pkg::MARK_MARU);
                  default: seq.push_back(pick_byte(161, 223));
               endcase
            end else if (r < 75) seq.push_back(pick_byte(32, 126));
            else if (r < 80) begin
               seq.push_back($urandom_range(0, 1) ? jt2sj_pkg::BYTE_CR : jt2sj_pkg::BYTE_FF);
            end else if (r < 94) seq.push_back(pick_byte(1, 255));
            else seq.push_back(jt2sj_pkg::BYTE_END);
         end
         foreach (seq[i]) send_byte(seq[i]);
         sent += seq.size();
      end
   endtask

   task automatic test_random_text();
      logic [1:0] enc_plan[6] = '{jt2sj_pkg::ENC_EUC_JP, jt2sj_pkg::ENC_ISO_2022_JP,
                                  ENC_SHIFT_JIS, ENC_SHIFT_JIS, ENC_SPARE,
                                  jt2sj_pkg::ENC_EUC_JP};
      logic [1:0] kana_plan[6] = '{KANA_HALF, KANA_FULL, KANA_HALF,
                                   KANA_FULL, KANA_FULL, KANA_FULL};
      for (int s = 0; s < 6; s++) begin
         write_reg(jt2sj_pkg::CSR_SOURCE_ENCODING, enc_plan[s]);
         write_reg(jt2sj_pkg::CSR_FULL_WIDTH_KANA, kana_plan[s]);
         no_idle = (s == 2);
         send_random_text(RANDOM_PER_SETTING);
         settings_run++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      csr_we = 1'b0;
      csr_index = jt2sj_pkg::CSR_SOURCE_ENCODING;
      csr_wdata = jt2sj_pkg::ENC_EUC_JP;
      enc_cfg = jt2sj_pkg::ENC_EUC_JP;
      kana_cfg = 1'b0;
      dec_phase = jt2sj_pkg::PH_IDLE;
      lead_byte = 8'd0;
      kana_byte = 8'd0;
      dbl_shift = 1'b0;
      mismatches = 0;
      quiet_cycles = 0;
      bytes_in = 0;
      bytes_out = 0;
      settings_run = 0;
      no_idle = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_euc_jp();
      test_iso_2022_jp();
      test_shift_jis();
      test_switch_mid_char();
      test_random_text();

      req_valid <= 1'b0;
      while (sjis_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("converted %0d source bytes into %0d shift-jis bytes", bytes_in, bytes_out);
      $display("directed cases for all encodings, then %0d random register settings",
               settings_run);
      if (mismatches == 0) begin
         $display("** japanese_text_to_shift_jis: PASSED **");
      end else begin
         $display("** japanese_text_to_shift_jis: FAILED **");
      end
      $finish;
   end

endmodule
